// File: design/smtk_pkg.sv
// smtk_pkg: shared types, constants and the 2^-x table for the softmax top-k router
// no dependencies; imported by every module of the router
`timescale 1ns / 1ps
`default_nettype none
package smtk_pkg;

	localparam int EXP_TAB_DEPTH = 256;
	localparam int EXP_IDX_W     = $clog2(EXP_TAB_DEPTH);
	localparam logic [16:0] LOG2E_Q16 = 17'd94548;
	localparam logic [63:0] LN2_Q32   = 64'd2977044472;
	localparam logic [16:0] ONE_Q16   = 17'h10000;
	localparam logic [15:0] W_SAT     = 16'hFFFF;
	localparam logic signed [15:0] LOGIT_MIN = 16'sh8000;
	localparam logic [6:0] TOP_K_RESET = 7'd2;

	typedef logic [16:0] exp_tab_t [EXP_TAB_DEPTH];

	typedef struct packed {
		logic clear;
		logic rotate;
	} smtk_cell_ctl_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_RD,
		ST_MUL,
		ST_EXPV,
		ST_DIVW,
		ST_DRAIN,
		ST_WSUM,
		ST_EDIV,
		ST_EWAIT,
		ST_EOUT,
		ST_CLEAR
	} smtk_state_t;

	// round(2^(-j/depth) * 2^16) from an alternating series of exp(-y)
	function automatic exp_tab_t build_exp_tab();
		exp_tab_t tab;
		logic [63:0] y;
		logic [63:0] term;
		logic signed [64:0] acc;
		logic [64:0] rnd;
		for (int j = 0; j < EXP_TAB_DEPTH; j++) begin
			y = (64'(j) * LN2_Q32) / EXP_TAB_DEPTH;
			term = 64'd1 << 32;
			acc = 65'sd1 <<< 32;
			for (int n = 1; n <= 16; n++) begin
				term = (term * y) >> 32;
				term = term / 64'(n);
				if (n % 2 == 1) begin
					acc = acc - $signed({1'b0, term});
				end else begin
					acc = acc + $signed({1'b0, term});
				end
			end
			if (acc < 0) begin
				acc = '0;
			end
			rnd = ($unsigned(acc) + 65'd32768) >> 16;
			tab[j] = rnd[16:0];
		end
		return tab;
	endfunction

	localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage
`default_nettype wire

// File: design/smtk_if.sv
// smtk_if: valid/ready channel interfaces for logits in and selections out
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
interface smtk_req_if;
	logic valid;
	logic ready;
	logic signed [15:0] logit;
	logic last_logit;
	modport source(output valid, output logit, output last_logit, input ready);
	modport sink(input valid, input logit, input last_logit, output ready);
endinterface

interface smtk_rsp_if;
	logic valid;
	logic ready;
	logic [7:0] expert_id;
	logic [15:0] weight;
	logic last_result;
	modport source(output valid, output expert_id, output weight, output last_result,
		input ready);
	modport sink(input valid, input expert_id, input weight, input last_result,
		output ready);
endinterface
`default_nettype wire

// File: design/smtk_exp.sv
// smtk_exp: exp(-d) in Q1.16 as a registered multiply by log2(e), table and shift
// depends on smtk_pkg
`timescale 1ns / 1ps
`default_nettype none
module smtk_exp (
	input  wire logic        clk,
	input  wire logic [15:0] d,
	output logic      [16:0] e
);
	import smtk_pkg::*;

	logic [32:0] x_s1;
	logic [8:0] ip;
	logic [EXP_IDX_W-1:0] idx;
	logic [16:0] tab_val;

	always_ff @(posedge clk) begin
		x_s1 <= 33'(d) * 33'(LOG2E_Q16);
	end

	always_comb begin
		ip = x_s1[32:24];
		idx = x_s1[23 -: EXP_IDX_W];
		tab_val = EXP_TAB[idx];
		if (ip >= 9'd17) begin
			e = '0;
		end else begin
			e = tab_val >> ip[4:0];
		end
	end
endmodule
`default_nettype wire

// File: design/smtk_div.sv
// smtk_div: restoring divider, the 16 fraction bits of a / den, one bit a cycle
// depends on smtk_pkg
`timescale 1ns / 1ps
`default_nettype none
module smtk_div #(
	parameter int DW = 26
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [16:0]   a,
	input  wire logic [DW-1:0] den,
	output logic               done,
	output logic               full,
	output logic [15:0]        q
);
	import smtk_pkg::*;

	logic busy_q;
	logic done_q;
	logic [3:0] step_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [15:0] q_q;
	logic full_q;
	logic [DW:0] t;
	logic ge;
	logic [DW:0] diff;

	always_comb begin
		t = {rem_q, 1'b0};
		ge = t >= {1'b0, den_q};
		diff = t - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 4'd1;
				if (step_q == 4'd15) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DW'(a);
			den_q <= den;
			full_q <= DW'(a) >= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DW-1:0] : t[DW-1:0];
			q_q <= {q_q[14:0], ge};
		end
	end

	assign done = done_q;
	assign full = full_q;
	assign q = q_q;
endmodule
`default_nettype wire

// File: design/smtk_cell.sv
// smtk_cell: one slot of the sorted top-k chain, keeps the better of held and incoming
// depends on smtk_pkg
`timescale 1ns / 1ps
`default_nettype none
module smtk_cell #(
	parameter int IW = 8
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire smtk_pkg::smtk_cell_ctl_t ctl,
	input  wire logic                     in_v,
	input  wire logic [16:0]              in_p,
	input  wire logic [IW-1:0]            in_i,
	input  wire logic                     rot_v,
	input  wire logic [16:0]              rot_p,
	input  wire logic [IW-1:0]            rot_i,
	output logic                          hold_v,
	output logic [16:0]                   hold_p,
	output logic [IW-1:0]                 hold_i,
	output logic                          pass_v,
	output logic [16:0]                   pass_p,
	output logic [IW-1:0]                 pass_i
);
	import smtk_pkg::*;

	logic hold_v_q, pass_v_q;
	logic [16:0] hold_p_q, pass_p_q;
	logic [IW-1:0] hold_i_q, pass_i_q;
	logic wins;

	// larger probability first, lower index on a tie
	always_comb begin
		wins = in_v && (!hold_v_q || (in_p > hold_p_q) ||
			((in_p == hold_p_q) && (in_i < hold_i_q)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			pass_v_q <= 1'b0;
		end else if (ctl.clear) begin
			hold_v_q <= 1'b0;
			pass_v_q <= 1'b0;
		end else if (ctl.rotate) begin
			hold_v_q <= rot_v;
			pass_v_q <= 1'b0;
		end else if (wins) begin
			hold_v_q <= 1'b1;
			pass_v_q <= hold_v_q;
		end else begin
			pass_v_q <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rotate) begin
			hold_p_q <= rot_p;
			hold_i_q <= rot_i;
		end else if (wins) begin
			hold_p_q <= in_p;
			hold_i_q <= in_i;
			pass_p_q <= hold_p_q;
			pass_i_q <= hold_i_q;
		end else begin
			pass_p_q <= in_p;
			pass_i_q <= in_i;
		end
	end

	assign hold_v = hold_v_q;
	assign hold_p = hold_p_q;
	assign hold_i = hold_i_q;
	assign pass_v = pass_v_q;
	assign pass_p = pass_p_q;
	assign pass_i = pass_i_q;
endmodule
`default_nettype wire

// File: design/softmax_topk_router.sv
// softmax top-k router: one transaction per cycle while logits load; after the last logit
// one sweep sums the exponentials of the n logits; a second divides each by that sum with
// the 16-step divider, used once per expert and once per pick, then the chain drains;
// results leave one per output transaction, each after its own divide
// asynchronous active-low reset clears control, top_k to 2 and the chain valid bits
// the logit store has no reset; only entries written for the current token are read
`timescale 1ns / 1ps
`default_nettype none
module softmax_topk_router #(
	parameter int MAX_EXPERTS = 256,
	parameter int MAX_TOP_K   = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	smtk_req_if.sink        req,
	smtk_rsp_if.source      rsp,
	input  wire logic       cfg_we,
	input  wire logic [6:0] cfg_wdata
);
	import smtk_pkg::*;

	localparam int AW  = (MAX_EXPERTS > 1) ? $clog2(MAX_EXPERTS) : 1;
	localparam int CW  = $clog2(MAX_EXPERTS + 1);
	localparam int KW  = $clog2(MAX_TOP_K + 1);
	localparam int RW  = $clog2(MAX_TOP_K + 3);
	localparam int ESW = 17 + CW;
	localparam int WSW = 17 + KW;
	localparam int DW  = (ESW > WSW) ? ESW : WSW;
	localparam int LW  = 12;

	// control
	smtk_state_t state_q, state_d;
	logic pass_prob_q;
	logic [6:0] top_k_q;
	logic [CW-1:0] cnt_q;
	logic [AW-1:0] ptr_q;
	logic [AW-1:0] n_m1;
	logic [KW-1:0] k_q;
	logic [KW-1:0] r_q;
	logic [RW-1:0] rot_q;
	logic req_acc, rsp_acc;
	logic ptr_last;

	// datapath
	logic signed [15:0] score_mem [MAX_EXPERTS];
	logic signed [15:0] rd_q;
	logic signed [15:0] max_q;
	logic [ESW-1:0] sum_q;
	logic [WSW-1:0] wsum_q;
	logic [WSW-1:0] wsum_fl;
	logic signed [16:0] diff;
	logic [16:0] e_val;

	// divider
	logic div_start, div_done, div_full;
	logic [16:0] div_a;
	logic [DW-1:0] div_den;
	logic [15:0] div_q;

	// chain
	smtk_cell_ctl_t cell_ctl;
	logic push_v_q;
	logic [16:0] push_p_q;
	logic [AW-1:0] push_i_q;
	logic          hv [MAX_TOP_K];
	logic [16:0]   hp [MAX_TOP_K];
	logic [AW-1:0] hi [MAX_TOP_K];
	logic          pv [MAX_TOP_K];
	logic [16:0]   pp [MAX_TOP_K];
	logic [AW-1:0] pi [MAX_TOP_K];

	// output register
	logic out_v_q;
	logic [7:0] out_id_q;
	logic [15:0] out_w_q;
	logic out_last_q;
	logic [AW+7:0] id_ext;
	logic [LW-1:0] k_calc;

	assign req_acc = req.valid && req.ready;
	assign rsp_acc = rsp.valid && rsp.ready;
	assign n_m1 = AW'(cnt_q - CW'(1));
	assign ptr_last = (ptr_q == n_m1);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_k_q <= TOP_K_RESET;
		end else if (cfg_we) begin
			top_k_q <= cfg_wdata;
		end
	end

	// logit store, registered read at the sweep pointer
	always_ff @(posedge clk) begin
		if (req_acc && (cnt_q < CW'(MAX_EXPERTS))) begin
			score_mem[cnt_q[AW-1:0]] <= req.logit;
		end
		rd_q <= score_mem[ptr_q];
	end

	// exponential of (max - logit)
	always_comb begin
		diff = 17'(max_q) - 17'(rd_q);
	end

	smtk_exp u_exp (
		.clk (clk),
		.d   (diff[15:0]),
		.e   (e_val)
	);

	// shared divider: probabilities over exp_sum, then weights over the pick sum
	always_comb begin
		wsum_fl = (wsum_q < WSW'(4)) ? WSW'(4) : wsum_q;
		div_start = (state_q == ST_EDIV) || ((state_q == ST_EXPV) && pass_prob_q);
		if (state_q == ST_EDIV) begin
			div_a = hp[0];
			div_den = DW'(wsum_fl);
		end else begin
			div_a = e_val;
			div_den = DW'(sum_q);
		end
	end

	smtk_div #(.DW(DW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.a      (div_a),
		.den    (div_den),
		.done   (div_done),
		.full   (div_full),
		.q      (div_q)
	);

	// sorted chain of top-k cells; inserts flow toward the tail, rotation toward the head
	always_comb begin
		cell_ctl.clear = (state_q == ST_CLEAR);
		cell_ctl.rotate = (state_q == ST_WSUM) || ((state_q == ST_EOUT) && rsp_acc);
	end

	for (genvar j = 0; j < MAX_TOP_K; j++) begin : g_cell
		logic          in_v, r_v;
		logic [16:0]   in_p, r_p;
		logic [AW-1:0] in_i, r_i;
		if (j == 0) begin : g_head
			assign in_v = push_v_q;
			assign in_p = push_p_q;
			assign in_i = push_i_q;
		end else begin : g_body
			assign in_v = pv[j-1];
			assign in_p = pp[j-1];
			assign in_i = pi[j-1];
		end
		if (j == MAX_TOP_K - 1) begin : g_tail
			assign r_v = hv[0];
			assign r_p = hp[0];
			assign r_i = hi[0];
		end else begin : g_mid
			assign r_v = hv[j+1];
			assign r_p = hp[j+1];
			assign r_i = hi[j+1];
		end
		smtk_cell #(.IW(AW)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (cell_ctl),
			.in_v   (in_v),
			.in_p   (in_p),
			.in_i   (in_i),
			.rot_v  (r_v),
			.rot_p  (r_p),
			.rot_i  (r_i),
			.hold_v (hv[j]),
			.hold_p (hp[j]),
			.hold_i (hi[j]),
			.pass_v (pv[j]),
			.pass_p (pp[j]),
			.pass_i (pi[j])
		);
	end

	// number of results: min(top_k, MAX_TOP_K, logits stored)
	always_comb begin
		k_calc = LW'(top_k_q);
		if (k_calc > LW'(MAX_TOP_K)) begin
			k_calc = LW'(MAX_TOP_K);
		end
		if (k_calc > LW'(cnt_q)) begin
			k_calc = LW'(cnt_q);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (req_acc && req.last_logit) begin
					state_d = ST_RD;
				end
			end
			ST_RD: state_d = ST_MUL;
			ST_MUL: state_d = ST_EXPV;
			ST_EXPV: begin
				state_d = pass_prob_q ? ST_DIVW : ST_RD;
			end
			ST_DIVW: begin
				if (div_done) begin
					state_d = ptr_last ? ST_DRAIN : ST_RD;
				end
			end
			ST_DRAIN: begin
				if (rot_q == RW'(MAX_TOP_K + 1)) begin
					state_d = ST_WSUM;
				end
			end
			ST_WSUM: begin
				if (rot_q == RW'(MAX_TOP_K - 1)) begin
					state_d = (k_q == '0) ? ST_CLEAR : ST_EDIV;
				end
			end
			ST_EDIV: state_d = ST_EWAIT;
			ST_EWAIT: begin
				if (div_done) begin
					state_d = ST_EOUT;
				end
			end
			ST_EOUT: begin
				if (rsp_acc) begin
					state_d = (r_q + KW'(1) == k_q) ? ST_CLEAR : ST_EDIV;
				end
			end
			ST_CLEAR: state_d = ST_LOAD;
			default: state_d = ST_LOAD;
		endcase
	end

	// handshake outputs
	always_comb begin
		req.ready = (state_q == ST_LOAD);
		rsp.valid = out_v_q;
		rsp.expert_id = out_id_q;
		rsp.weight = out_w_q;
		rsp.last_result = out_last_q;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			pass_prob_q <= 1'b0;
			cnt_q <= '0;
			ptr_q <= '0;
			k_q <= '0;
			r_q <= '0;
			rot_q <= '0;
			push_v_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			push_v_q <= 1'b0;
			unique case (state_q)
				ST_LOAD: begin
					if (req_acc && (cnt_q < CW'(MAX_EXPERTS))) begin
						cnt_q <= cnt_q + CW'(1);
					end
					ptr_q <= '0;
					pass_prob_q <= 1'b0;
				end
				ST_EXPV: begin
					if (!pass_prob_q) begin
						if (ptr_last) begin
							ptr_q <= '0;
							pass_prob_q <= 1'b1;
						end else begin
							ptr_q <= ptr_q + AW'(1);
						end
					end
				end
				ST_DIVW: begin
					if (div_done) begin
						push_v_q <= 1'b1;
						ptr_q <= ptr_q + AW'(1);
						rot_q <= '0;
					end
				end
				ST_DRAIN: begin
					k_q <= k_calc[KW-1:0];
					rot_q <= (state_d == ST_WSUM) ? '0 : rot_q + RW'(1);
				end
				ST_WSUM: begin
					rot_q <= rot_q + RW'(1);
					r_q <= '0;
				end
				ST_EWAIT: begin
					if (div_done) begin
						out_v_q <= 1'b1;
					end
				end
				ST_EOUT: begin
					if (rsp_acc) begin
						out_v_q <= 1'b0;
						r_q <= r_q + KW'(1);
					end
				end
				ST_CLEAR: begin
					cnt_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_comb begin
		id_ext = (AW + 8)'(hi[0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= LOGIT_MIN;
		end else if (state_q == ST_CLEAR) begin
			max_q <= LOGIT_MIN;
		end else if (req_acc && (cnt_q < CW'(MAX_EXPERTS)) && (req.logit > max_q)) begin
			max_q <= req.logit;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			sum_q <= '0;
		end else if ((state_q == ST_EXPV) && !pass_prob_q) begin
			sum_q <= sum_q + ESW'(e_val);
		end
		if ((state_q == ST_DIVW) && div_done) begin
			push_p_q <= div_full ? ONE_Q16 : {1'b0, div_q};
			push_i_q <= ptr_q;
		end
		if (state_q == ST_DRAIN) begin
			wsum_q <= '0;
		end else if ((state_q == ST_WSUM) && (RW'(k_q) > rot_q)) begin
			wsum_q <= wsum_q + WSW'(hp[0]);
		end
		if ((state_q == ST_EWAIT) && div_done) begin
			out_id_q <= id_ext[7:0];
			out_w_q <= div_full ? W_SAT : div_q;
			out_last_q <= (r_q + KW'(1) == k_q);
		end
	end
endmodule
`default_nettype wire

// File: test/smtk_tb_if.sv
// smtk_tb_pkg: the pick_t selection record; no extra interfaces needed, and the design
// interfaces smtk_req_if and smtk_rsp_if are reused by the testbench
`timescale 1ns / 1ps
package smtk_tb_pkg;
	typedef struct {
		logic [7:0] expert_id;
		logic [15:0] weight;
		logic last_result;
	} pick_t;
endpackage

// File: test/softmax_topk_router_tb.sv
// softmax_topk_router_tb: drives tokens of logits through the router and checks every selection
// depends on smtk_pkg, smtk_tb_pkg, smtk_if and the softmax_topk_router rtl
`timescale 1ns / 1ps
module softmax_topk_router_tb;
	import smtk_pkg::*;
	import smtk_tb_pkg::*;

	localparam int NEXP = 256;
	localparam int NTOPK = 64;

	// builds the 2^-x table independently from the same alternating series
	class router_scoreboard;
		logic [16:0] tab [256];
		int top_k;
		int cnt;
		int signed logits [NEXP];
		int signed vmax;
		pick_t pending [$];
		int errors;
		int checked;

		function new();
			longint unsigned y, term;
			longint signed acc;
			for (int j = 0; j < 256; j++) begin
				y = (longint'(j) * 64'd2977044472) / 256;
				term = 64'd1 << 32;
				acc = 64'sd1 <<< 32;
				for (int n = 1; n <= 16; n++) begin
					term = (term * y) >> 32;
					term = term / n;
					if (n % 2 == 1) begin
						acc = acc - longint'(term);
					end else begin
						acc = acc + longint'(term);
					end
				end
				if (acc < 0) begin
					acc = 0;
				end
				tab[j] = 17'((acc + 32768) >>> 16);
			end
			top_k = 2;
			cnt = 0;
			vmax = -32768;
			errors = 0;
			checked = 0;
		endfunction

		function automatic longint unsigned exp_of(int unsigned d);
			longint unsigned x, ip, idx;
			x = longint'(d) * 94548;
			ip = x >> 24;
			idx = ((x & 64'hFFFFFF) * 256) >> 24;
			if (ip >= 17) begin
				return 0;
			end
			return tab[idx] >> ip;
		endfunction

		// notes one accepted logit; on the last one, predicts the selections
		function void note_logit(logic signed [15:0] lg, logic lst);
			longint unsigned p [NEXP];
			bit taken [NEXP];
			int picks [$];
			longint unsigned esum, wsum, w;
			int k, best;
			pick_t r;
			if (cnt < NEXP) begin
				logits[cnt] = lg;
				cnt++;
				if (int'(lg) > vmax) begin
					vmax = lg;
				end
			end
			if (!lst) begin
				return;
			end
			esum = 0;
			for (int i = 0; i < cnt; i++) begin
				p[i] = exp_of(vmax - logits[i]);
				esum += p[i];
				taken[i] = 0;
			end
			for (int i = 0; i < cnt; i++) begin
				p[i] = esum != 0 ? (p[i] << 16) / esum : 0;
			end
			k = top_k > NTOPK ? NTOPK : top_k;
			if (k > cnt) begin
				k = cnt;
			end
			wsum = 0;
			for (int q = 0; q < k; q++) begin
				best = -1;
				for (int i = 0; i < cnt; i++) begin
					if (!taken[i] && (best < 0 || p[i] > p[best])) begin
						best = i;
					end
				end
				taken[best] = 1;
				picks.push_back(best);
				wsum += p[best];
			end
			if (wsum < 4) begin
				wsum = 4;
			end
			for (int q = 0; q < k; q++) begin
				w = (p[picks[q]] << 16) / wsum;
				r.expert_id = 8'(picks[q]);
				r.weight = w > 65535 ? 16'hFFFF : 16'(w);
				r.last_result = (q + 1 == k);
				pending.push_back(r);
			end
			cnt = 0;
			vmax = -32768;
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			errors++;
			$display("mismatch on selection %0d: %s got %0d want %0d", checked, what, got, want);
		endtask

		task check_pick(logic [7:0] id, logic [15:0] wt, logic lst);
			pick_t e;
			if (pending.size() == 0) begin
				report("unexpected selection, expert_id", id, 0);
				return;
			end
			e = pending.pop_front();
			if (id !== e.expert_id) report("expert_id", id, e.expert_id);
			if (wt !== e.weight) report("weight", wt, e.weight);
			if (lst !== e.last_result) report("last_result", lst, e.last_result);
			checked++;
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [6:0] cfg_wdata = '0;
	bit stall_free = 0;
	int n_tokens = 0;

	smtk_req_if req();
	smtk_rsp_if rsp();
	router_scoreboard sb = new();

	softmax_topk_router i_dut (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	initial begin
		req.valid = 0;
		req.logit = '0;
		req.last_logit = 0;
		rsp.ready = 0;
	end

	// each transaction is sampled on the rising edge, so the scoreboard sees it once
	always @(posedge clk) begin
		if (arst_n && req.valid && req.ready) begin
			sb.note_logit(req.logit, req.last_logit);
		end
		if (arst_n && rsp.valid && rsp.ready) begin
			sb.check_pick(rsp.expert_id, rsp.weight, rsp.last_result);
		end
	end

	// sink side: random backpressure except during the stall-free stretch
	always @(negedge clk) begin
		if (arst_n) begin
			rsp.ready <= stall_free || ($urandom_range(99) >= 18);
		end
	end

	// drives one logit and holds it until the transaction completes
	// valid stays high afterwards; an idle cycle inserted by the next call or a drain drops it
	task send_logit(logic signed [15:0] lg, logic lst);
		while (!stall_free && $urandom_range(99) < 18) begin
			req.valid <= 0;
			@(negedge clk);
		end
		req.valid <= 1;
		req.logit <= lg;
		req.last_logit <= lst;
		@(posedge clk);
		while (!req.ready) begin
			@(posedge clk);
		end
		@(negedge clk);
		if (lst) begin
			n_tokens++;
		end
	endtask

	// register writes happen only with nothing outstanding and the block drained
	task write_top_k(logic [6:0] val);
		req.valid <= 0;
		while (sb.pending.size() != 0) begin
			@(negedge clk);
		end
		repeat (200) @(negedge clk);
		cfg_we <= 1;
		cfg_wdata <= val;
		sb.top_k = val;
		@(negedge clk);
		cfg_we <= 0;
	endtask

	// a token of n logits; mostly near each other so probabilities are not all zero
	task send_token(int n, int spread);
		logic signed [15:0] base;
		base = 16'($urandom);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(9) == 0) begin
				send_logit(16'($urandom), i == n - 1);
			end else begin
				send_logit(16'(int'(base) + int'($urandom_range(2 * spread)) - spread),
					i == n - 1);
			end
		end
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: default top_k, field extremes, single logit, ties to lowest index, top_k 0, 127 and 1
		send_logit(16'sh7FFF, 0);
		send_logit(16'sh8000, 1);
		send_logit(16'sh0000, 1);
		send_logit(16'sh0100, 0);
		send_logit(16'sh0100, 0);
		send_logit(16'sh0100, 1);
		write_top_k(7'd0);
		send_logit(16'sh1234, 0);
		send_logit(16'shFFFF, 1);
		write_top_k(7'd127);
		send_logit(16'sh5555, 0);
		send_logit(16'shAAAA, 0);
		send_logit(16'sh0000, 1);
		write_top_k(7'd1);
		send_logit(16'sh8000, 0);
		send_logit(16'sh8000, 1);

		// random tokens across settings
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: write_top_k(7'd3);
				1: write_top_k(7'd8);
				2: write_top_k(7'($urandom_range(1, 64)));
				3: write_top_k(7'd2);
				default: write_top_k(7'd64);
			endcase
			stall_free = (ph == 3);
			for (int t = 0; t < 8; t++) begin
				send_token($urandom_range(1, 9), $urandom_range(1, 2000));
			end
		end
		stall_free = 0;

		req.valid <= 0;
		while (sb.pending.size() != 0) begin
			@(negedge clk);
		end
		repeat (200) @(negedge clk);
		$display("covered %0d tokens, %0d selections checked, top_k from 0 to 127",
			n_tokens, sb.checked);
		if (sb.errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("timeout with %0d selections outstanding", sb.pending.size());
		$display("RESULT: ERROR");
		$finish;
	end
endmodule
